### rtl/core/rcs_pkg.sv
package rcs_pkg;

  localparam int VAL_W = 48;
  localparam int SUM_W = 64;
  localparam int AXES  = 3;

  typedef enum logic [3:0] {
    KIND_ENDMIN   = 4'd0,
    KIND_ENDMAX   = 4'd1,
    KIND_STARTMIN = 4'd2,
    KIND_STARTMAX = 4'd3,
    KIND_RAYMIN   = 4'd4,
    KIND_RAYMAX   = 4'd5,
    KIND_CENTROID = 4'd6,
    KIND_FIRSTPOS = 4'd7,
    KIND_LASTPOS  = 4'd8,
    KIND_TIMES    = 4'd9,
    KIND_COUNTS   = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } back_state_t;

endpackage

### rtl/core/rcs_front.sv
module rcs_front #(
  parameter int COORD_WIDTH = 32,
  parameter int TIME_WIDTH  = 48,
  parameter int EW          = 6 * COORD_WIDTH + TIME_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_z,
  input  logic signed [TIME_WIDTH-1:0]  in_time_stamp,
  input  logic        [7:0]             in_alpha,
  input  logic                          in_last_ray,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic        [EW-1:0]          q_word
);

  logic [EW-1:0] slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          bounded;

  assign bounded  = (in_alpha != 8'd0);
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= {in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z,
                           in_time_stamp, bounded, in_last_ray};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

### rtl/core/rcs_div.sv
module rcs_div #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rcs_pkg::SUM_W-1:0]   dividend,
  input  logic        [COUNT_WIDTH-1:0]      divisor,
  output logic                               done,
  output logic        [rcs_pkg::SUM_W-1:0]   quotient
);

  localparam int SW     = rcs_pkg::SUM_W;
  localparam int STEP_W = $clog2(SW + 1);

  logic                   busy_r, done_r, neg_r;
  logic [STEP_W-1:0]      step_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [SW-1:0]          quo_r;
  logic [COUNT_WIDTH:0]   trial, diff;
  logic                   ge;

  assign trial    = {rem_r, quo_r[SW-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + SW'(1)) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(SW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // magnitude restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      neg_r  <= dividend[SW-1];
      rem_r  <= '0;
      quo_r  <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      quo_r  <= {quo_r[SW-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

### rtl/core/rcs_back.sv
module rcs_back #(
  parameter int COORD_WIDTH = 32,
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32,
  parameter int EW          = 6 * COORD_WIDTH + TIME_WIDTH + 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic        [EW-1:0]              q_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [3:0]                 out_kind,
  output logic signed [rcs_pkg::VAL_W-1:0]  out_value_x,
  output logic signed [rcs_pkg::VAL_W-1:0]  out_value_y,
  output logic signed [rcs_pkg::VAL_W-1:0]  out_value_z,
  output logic                              out_empty_flag,
  output logic                              out_last_result
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int VW = rcs_pkg::VAL_W;
  localparam int SW = rcs_pkg::SUM_W;
  localparam int NA = rcs_pkg::AXES;

  localparam logic signed [CW-1:0] C_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_LO = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_HI = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_LO = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_HI = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_LO = {1'b1, {(SW-1){1'b0}}};

  rcs_pkg::back_state_t state_r, state_nxt;
  rcs_pkg::kind_t       kind_r;
  logic                 div_start, div_done;
  logic [1:0]           axis_r;

  logic signed [CW-1:0] bnd_lo_r [NA];
  logic signed [CW-1:0] bnd_hi_r [NA];
  logic signed [CW-1:0] st_lo_r  [NA];
  logic signed [CW-1:0] st_hi_r  [NA];
  logic signed [CW-1:0] end_lo_r [NA];
  logic signed [CW-1:0] end_hi_r [NA];
  logic signed [SW-1:0] sum_r    [NA];
  logic signed [CW-1:0] first_r  [NA];
  logic signed [CW-1:0] final_r  [NA];
  logic signed [VW-1:0] cen_r    [NA];
  logic [COUNT_WIDTH-1:0] rays_r, bnd_cnt_r;
  logic signed [TW-1:0]   t_min_r, t_max_r;

  logic signed [CW-1:0] s [NA];
  logic signed [CW-1:0] e [NA];
  logic signed [CW-1:0] ray_lo [NA];
  logic signed [CW-1:0] ray_hi [NA];
  logic signed [SW:0]   wide_sum [NA];
  logic signed [TW-1:0] t;
  logic                 bounded, last, first, no_rays, no_bnd;
  logic                 emit_load, clear;
  logic [SW-1:0]        quotient;

  logic                 ov_r, emp_r, lastres_r;
  logic [3:0]           okind_r;
  logic signed [VW-1:0] ox_r, oy_r, oz_r;
  logic signed [VW-1:0] vx, vy, vz;
  logic                 vemp;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      s[i] = q_word[EW-1-i*CW -: CW];
      e[i] = q_word[EW-1-(i+NA)*CW -: CW];
      wide_sum[i] = (SW+1)'(sum_r[i]) + (SW+1)'(e[i]);
      ray_lo[i] = (end_lo_r[i] < st_lo_r[i]) ? end_lo_r[i] : st_lo_r[i];
      ray_hi[i] = (end_hi_r[i] > st_hi_r[i]) ? end_hi_r[i] : st_hi_r[i];
    end
  end

  assign t       = q_word[TW+1:2];
  assign bounded = q_word[1];
  assign last    = q_word[0];
  assign first   = (rays_r == '0);
  assign no_rays = (rays_r == '0);
  assign no_bnd  = (bnd_cnt_r == '0);

  rcs_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[axis_r]),
    .divisor  (bnd_cnt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcs_pkg::ST_ACC:      if (q_valid && last) state_nxt = rcs_pkg::ST_DIV_GO;
      rcs_pkg::ST_DIV_GO:   state_nxt = rcs_pkg::ST_DIV_WAIT;
      rcs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (axis_r == 2'd2) ? rcs_pkg::ST_EMIT : rcs_pkg::ST_DIV_GO;
        end
      end
      rcs_pkg::ST_EMIT: begin
        if (emit_load && kind_r == rcs_pkg::KIND_COUNTS) state_nxt = rcs_pkg::ST_ACC;
      end
      default:              state_nxt = rcs_pkg::ST_ACC;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      rcs_pkg::ST_ACC:      q_pop = q_valid;
      rcs_pkg::ST_DIV_GO:   div_start = 1'b1;
      rcs_pkg::ST_DIV_WAIT: ;
      rcs_pkg::ST_EMIT:     emit_load = !ov_r || !out_stall;
      default:              ;
    endcase
  end

  assign clear = emit_load && (kind_r == rcs_pkg::KIND_COUNTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcs_pkg::ST_ACC;
      axis_r  <= 2'd0;
      kind_r  <= rcs_pkg::KIND_ENDMIN;
    end else begin
      state_r <= state_nxt;
      if (state_r == rcs_pkg::ST_DIV_WAIT && div_done) begin
        axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
      end
      if (emit_load) begin
        kind_r <= clear ? rcs_pkg::KIND_ENDMIN : rcs_pkg::kind_t'(kind_r + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rcs_pkg::ST_DIV_WAIT && div_done) begin
      cen_r[axis_r] <= no_bnd ? '0 : VW'(quotient);
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < NA; i++) begin
        bnd_lo_r[i] <= C_HI;  bnd_hi_r[i] <= C_LO;
        st_lo_r[i]  <= C_HI;  st_hi_r[i]  <= C_LO;
        end_lo_r[i] <= C_HI;  end_hi_r[i] <= C_LO;
        sum_r[i]    <= '0;
        first_r[i]  <= '0;    final_r[i]  <= '0;
      end
      rays_r    <= '0;
      bnd_cnt_r <= '0;
      t_min_r   <= T_HI;
      t_max_r   <= T_LO;
    end else if (q_pop) begin
      for (int i = 0; i < NA; i++) begin
        if (bounded) begin
          if (e[i] < bnd_lo_r[i]) bnd_lo_r[i] <= e[i];
          if (e[i] > bnd_hi_r[i]) bnd_hi_r[i] <= e[i];
          if (bnd_cnt_r != '1) begin
            if (wide_sum[i][SW] != wide_sum[i][SW-1]) begin
              sum_r[i] <= wide_sum[i][SW] ? S_LO : S_HI;
            end else begin
              sum_r[i] <= wide_sum[i][SW-1:0];
            end
          end
        end
        if (s[i] < st_lo_r[i]) st_lo_r[i] <= s[i];
        if (s[i] > st_hi_r[i]) st_hi_r[i] <= s[i];
        if (e[i] < end_lo_r[i]) end_lo_r[i] <= e[i];
        if (e[i] > end_hi_r[i]) end_hi_r[i] <= e[i];
        if (first || t < t_min_r) first_r[i] <= s[i];
        if (first || t > t_max_r) final_r[i] <= s[i];
      end
      if (bounded && bnd_cnt_r != '1) bnd_cnt_r <= bnd_cnt_r + COUNT_WIDTH'(1);
      if (rays_r != '1) rays_r <= rays_r + COUNT_WIDTH'(1);
      if (first || t < t_min_r) t_min_r <= t;
      if (first || t > t_max_r) t_max_r <= t;
    end
  end

  always_comb begin
    vx   = '0;
    vy   = '0;
    vz   = '0;
    vemp = no_rays;
    case (kind_r)
      rcs_pkg::KIND_ENDMIN: begin
        vx = VW'(bnd_lo_r[0]); vy = VW'(bnd_lo_r[1]); vz = VW'(bnd_lo_r[2]); vemp = no_bnd;
      end
      rcs_pkg::KIND_ENDMAX: begin
        vx = VW'(bnd_hi_r[0]); vy = VW'(bnd_hi_r[1]); vz = VW'(bnd_hi_r[2]); vemp = no_bnd;
      end
      rcs_pkg::KIND_STARTMIN: begin
        vx = VW'(st_lo_r[0]); vy = VW'(st_lo_r[1]); vz = VW'(st_lo_r[2]);
      end
      rcs_pkg::KIND_STARTMAX: begin
        vx = VW'(st_hi_r[0]); vy = VW'(st_hi_r[1]); vz = VW'(st_hi_r[2]);
      end
      rcs_pkg::KIND_RAYMIN: begin
        vx = VW'(ray_lo[0]); vy = VW'(ray_lo[1]); vz = VW'(ray_lo[2]);
      end
      rcs_pkg::KIND_RAYMAX: begin
        vx = VW'(ray_hi[0]); vy = VW'(ray_hi[1]); vz = VW'(ray_hi[2]);
      end
      rcs_pkg::KIND_CENTROID: begin
        vx = cen_r[0]; vy = cen_r[1]; vz = cen_r[2]; vemp = no_bnd;
      end
      rcs_pkg::KIND_FIRSTPOS: begin
        vx = VW'(first_r[0]); vy = VW'(first_r[1]); vz = VW'(first_r[2]);
      end
      rcs_pkg::KIND_LASTPOS: begin
        vx = VW'(final_r[0]); vy = VW'(final_r[1]); vz = VW'(final_r[2]);
      end
      rcs_pkg::KIND_TIMES: begin
        vx = VW'(t_min_r); vy = VW'(t_max_r);
      end
      rcs_pkg::KIND_COUNTS: begin
        vx = VW'(rays_r); vy = VW'(bnd_cnt_r);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      okind_r   <= kind_r;
      ox_r      <= vx;
      oy_r      <= vy;
      oz_r      <= vz;
      emp_r     <= vemp;
      lastres_r <= (kind_r == rcs_pkg::KIND_COUNTS);
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_value_x     = ox_r;
  assign out_value_y     = oy_r;
  assign out_value_z     = oz_r;
  assign out_empty_flag  = emp_r;
  assign out_last_result = lastres_r;

endmodule

### rtl/core/ray_cloud_summary_stats.sv
// Streaming summary of a ray cloud: bounding boxes, centroid, first/last start position,
// time span and counts. Rays enter a two-word queue and are folded into the accumulators
// at one ray per cycle while no cloud is being closed. A ray flagged last_ray closes the
// cloud: the centroid is then worked out axis by axis by one shared bit-serial divider,
// and the eleven results leave through an output register at one word per cycle unless
// out_stall holds them. Rays keep filling the queue during that time and are stalled
// once it is full.
module ray_cloud_summary_stats #(
  parameter int COORD_WIDTH = 32,
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_start_x,
  input  logic signed [COORD_WIDTH-1:0]     in_start_y,
  input  logic signed [COORD_WIDTH-1:0]     in_start_z,
  input  logic signed [COORD_WIDTH-1:0]     in_end_x,
  input  logic signed [COORD_WIDTH-1:0]     in_end_y,
  input  logic signed [COORD_WIDTH-1:0]     in_end_z,
  input  logic signed [TIME_WIDTH-1:0]      in_time_stamp,
  input  logic        [7:0]                 in_alpha,
  input  logic                              in_last_ray,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [3:0]                 out_kind,
  output logic signed [rcs_pkg::VAL_W-1:0]  out_value_x,
  output logic signed [rcs_pkg::VAL_W-1:0]  out_value_y,
  output logic signed [rcs_pkg::VAL_W-1:0]  out_value_z,
  output logic                              out_empty_flag,
  output logic                              out_last_result
);

  localparam int EW = 6 * COORD_WIDTH + TIME_WIDTH + 2;

  logic          q_valid, q_pop;
  logic [EW-1:0] q_word;

  rcs_front #(.COORD_WIDTH(COORD_WIDTH), .TIME_WIDTH(TIME_WIDTH), .EW(EW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_start_z    (in_start_z),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_end_z      (in_end_z),
    .in_time_stamp (in_time_stamp),
    .in_alpha      (in_alpha),
    .in_last_ray   (in_last_ray),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_word        (q_word)
  );

  rcs_back #(
    .COORD_WIDTH(COORD_WIDTH), .TIME_WIDTH(TIME_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH), .EW(EW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_word          (q_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_value_x     (out_value_x),
    .out_value_y     (out_value_y),
    .out_value_z     (out_value_z),
    .out_empty_flag  (out_empty_flag),
    .out_last_result (out_last_result)
  );

endmodule

### rtl/core/rcs_checker.sv
module rcs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic        [3:0]                 out_kind,
  input logic signed [rcs_pkg::VAL_W-1:0]  out_value_x,
  input logic signed [rcs_pkg::VAL_W-1:0]  out_value_z,
  input logic                              out_empty_flag,
  input logic                              out_last_result
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_value_x))
    else $error("stalled result word changed");

  a_last_is_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_result == (out_kind == rcs_pkg::KIND_COUNTS)))
    else $error("last_result not on the counts word");

  a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rcs_pkg::KIND_COUNTS |-> out_value_x != '0 && !out_empty_flag)
    else $error("counts word reports no rays");

  a_z_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == rcs_pkg::KIND_TIMES || out_kind == rcs_pkg::KIND_COUNTS)
      |-> out_value_z == '0)
    else $error("z nonzero on times or counts word");

endmodule

bind ray_cloud_summary_stats rcs_checker u_rcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_value_x     (out_value_x),
  .out_value_z     (out_value_z),
  .out_empty_flag  (out_empty_flag),
  .out_last_result (out_last_result)
);

### dv/ray_cloud_summary_stats_tb.sv
`timescale 1ns / 100ps

module ray_cloud_summary_stats_tb;

  localparam int CW = 32;
  localparam int TW = 48;
  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;
  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam longint TIME_HI = 64'sd140737488355327;
  localparam longint TIME_LO = -64'sd140737488355328;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [47:0] vx;
    logic [47:0] vy;
    logic [47:0] vz;
    logic        empty;
    logic        last;
  } summary_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_start_x, in_start_y, in_start_z;
  logic signed [CW-1:0] in_end_x, in_end_y, in_end_z;
  logic signed [TW-1:0] in_time_stamp;
  logic [7:0] in_alpha;
  logic in_last_ray;
  logic out_valid;
  logic out_stall;
  logic [3:0] out_kind;
  logic signed [rcs_pkg::VAL_W-1:0] out_value_x, out_value_y, out_value_z;
  logic out_empty_flag;
  logic out_last_result;

  ray_cloud_summary_stats DUT (.*);

  // predictor state
  longint bend_lo[3], bend_hi[3], st_lo[3], st_hi[3], aend_lo[3], aend_hi[3];
  longint end_sum[3], first_pos[3], final_pos[3];
  longint unsigned ray_cnt, bnd_cnt;
  longint t_early, t_late;

  summary_word_t pending_summary[$];
  int send_idle_pct;
  int recv_idle_pct;
  int n_fail = 0;
  int n_rays = 0;
  int n_words = 0;
  int n_clouds = 0;
  longint cycle_cnt = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint sat_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (b > 0 && r < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b < 0 && r > a) return 64'sh8000_0000_0000_0000;
    return r;
  endfunction

  function automatic void clear_summary();
    for (int i = 0; i < 3; i++) begin
      bend_lo[i] = COORD_HI; st_lo[i] = COORD_HI; aend_lo[i] = COORD_HI;
      bend_hi[i] = COORD_LO; st_hi[i] = COORD_LO; aend_hi[i] = COORD_LO;
      end_sum[i] = 0; first_pos[i] = 0; final_pos[i] = 0;
    end
    ray_cnt = 0;
    bnd_cnt = 0;
    t_early = TIME_HI;
    t_late = TIME_LO;
  endfunction

  function automatic void push_word(rcs_pkg::kind_t k, longint x, longint y, longint z,
                                    bit e);
    summary_word_t w;
    w.kind = k;
    w.vx = x[47:0];
    w.vy = y[47:0];
    w.vz = z[47:0];
    w.empty = e;
    w.last = (k == rcs_pkg::KIND_COUNTS);
    pending_summary = {pending_summary, w};
  endfunction

  function automatic longint lo2(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint hi2(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic void fold_ray(longint s[3], longint e[3], longint t, bit [7:0] a,
                                   bit last);
    bit first;
    bit no_rays;
    bit no_bnd;
    longint cen[3];
    first = (ray_cnt == 0);
    if (a != 0) begin
      for (int i = 0; i < 3; i++) begin
        bend_lo[i] = lo2(bend_lo[i], e[i]);
        bend_hi[i] = hi2(bend_hi[i], e[i]);
      end
      if (bnd_cnt < CNT_MAX) begin
        for (int i = 0; i < 3; i++) end_sum[i] = sat_sum(end_sum[i], e[i]);
        bnd_cnt++;
      end
    end
    for (int i = 0; i < 3; i++) begin
      st_lo[i] = lo2(st_lo[i], s[i]);
      st_hi[i] = hi2(st_hi[i], s[i]);
      aend_lo[i] = lo2(aend_lo[i], e[i]);
      aend_hi[i] = hi2(aend_hi[i], e[i]);
    end
    if (first || t < t_early) begin
      for (int i = 0; i < 3; i++) first_pos[i] = s[i];
      t_early = t;
    end
    if (first || t > t_late) begin
      for (int i = 0; i < 3; i++) final_pos[i] = s[i];
      t_late = t;
    end
    if (ray_cnt < CNT_MAX) ray_cnt++;
    if (!last) return;
    no_rays = (ray_cnt == 0);
    no_bnd = (bnd_cnt == 0);
    // signed division in sv truncates toward zero
    for (int i = 0; i < 3; i++) cen[i] = no_bnd ? 0 : end_sum[i] / longint'(bnd_cnt);
    push_word(rcs_pkg::KIND_ENDMIN, bend_lo[0], bend_lo[1], bend_lo[2], no_bnd);
    push_word(rcs_pkg::KIND_ENDMAX, bend_hi[0], bend_hi[1], bend_hi[2], no_bnd);
    push_word(rcs_pkg::KIND_STARTMIN, st_lo[0], st_lo[1], st_lo[2], no_rays);
    push_word(rcs_pkg::KIND_STARTMAX, st_hi[0], st_hi[1], st_hi[2], no_rays);
    push_word(rcs_pkg::KIND_RAYMIN, lo2(aend_lo[0], st_lo[0]), lo2(aend_lo[1], st_lo[1]),
              lo2(aend_lo[2], st_lo[2]), no_rays);
    push_word(rcs_pkg::KIND_RAYMAX, hi2(aend_hi[0], st_hi[0]), hi2(aend_hi[1], st_hi[1]),
              hi2(aend_hi[2], st_hi[2]), no_rays);
    push_word(rcs_pkg::KIND_CENTROID, cen[0], cen[1], cen[2], no_bnd);
    push_word(rcs_pkg::KIND_FIRSTPOS, first_pos[0], first_pos[1], first_pos[2], no_rays);
    push_word(rcs_pkg::KIND_LASTPOS, final_pos[0], final_pos[1], final_pos[2], no_rays);
    push_word(rcs_pkg::KIND_TIMES, t_early, t_late, 0, no_rays);
    push_word(rcs_pkg::KIND_COUNTS, longint'(ray_cnt), longint'(bnd_cnt), 0, no_rays);
    n_clouds++;
    clear_summary();
  endfunction

  // valid stays high after an accepted word until the next word or an idle cycle
  task automatic send_ray(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] sz,
                          logic [CW-1:0] ex, logic [CW-1:0] ey, logic [CW-1:0] ez,
                          logic [TW-1:0] t, logic [7:0] a, logic last);
    longint s[3];
    longint e[3];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx; in_start_y <= sy; in_start_z <= sz;
    in_end_x <= ex; in_end_y <= ey; in_end_z <= ez;
    in_time_stamp <= t;
    in_alpha <= a;
    in_last_ray <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    s[0] = longint'($signed(sx)); s[1] = longint'($signed(sy)); s[2] = longint'($signed(sz));
    e[0] = longint'($signed(ex)); e[1] = longint'($signed(ey)); e[2] = longint'($signed(ez));
    fold_ray(s, e, longint'($signed(t)), a, last);
    n_rays++;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_time();
    case ($urandom_range(5))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return 48'($urandom_range(5));
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_random_ray(bit last);
    logic [7:0] a;
    a = $urandom_range(2) == 0 ? 8'd0 : 8'($urandom);
    send_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_time(), a, last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_summary.size() != 0) @(posedge clk);
  endtask

  // result side: stall and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        summary_word_t exp_w;
        n_words++;
        if (pending_summary.size() == 0) begin
          $error("unexpected word kind=%0d", out_kind);
          n_fail++;
        end else begin
          exp_w = pending_summary.pop_front();
          if (out_kind !== exp_w.kind) begin
            $error("kind exp=%0d got=%0d", exp_w.kind, out_kind); n_fail++;
          end
          if (out_value_x !== exp_w.vx) begin
            $error("value_x exp=%h got=%h (kind %0d)", exp_w.vx, out_value_x, exp_w.kind);
            n_fail++;
          end
          if (out_value_y !== exp_w.vy) begin
            $error("value_y exp=%h got=%h (kind %0d)", exp_w.vy, out_value_y, exp_w.kind);
            n_fail++;
          end
          if (out_value_z !== exp_w.vz) begin
            $error("value_z exp=%h got=%h (kind %0d)", exp_w.vz, out_value_z, exp_w.kind);
            n_fail++;
          end
          if (out_empty_flag !== exp_w.empty) begin
            $error("empty_flag exp=%0b got=%0b (kind %0d)", exp_w.empty, out_empty_flag,
                   exp_w.kind);
            n_fail++;
          end
          if (out_last_result !== exp_w.last) begin
            $error("last_result exp=%0b got=%0b (kind %0d)", exp_w.last, out_last_result,
                   exp_w.kind);
            n_fail++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_single_rays();
    // lone bounded ray, lone unbounded ray
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 5,
             48'h7FFF_FFFF_FFFF, 8'hFF, 1'b1);
    send_ray(1, 2, 3, 4, 5, 6, 48'h8000_0000_0000, 8'h00, 1'b1);
  endtask

  task automatic test_time_ties();
    // equal times keep the first ray's position, then a strictly new extreme
    send_ray(10, 20, 30, 1, 1, 1, 48'd100, 8'h01, 1'b0);
    send_ray(-10, -20, -30, 3, 3, 3, 48'd100, 8'h80, 1'b0);
    send_ray(7, 7, 7, -5, -5, -5, 48'd101, 8'h00, 1'b0);
    send_ray(8, 8, 8, -4, 4, -4, 48'd99, 8'h02, 1'b1);
  endtask

  task automatic test_centroid_rounding();
    // negative sums truncate toward zero
    send_ray(0, 0, 0, -7, 7, -1, 48'hFFFF_FFFF_FFFF, 8'h10, 1'b0);
    send_ray(0, 0, 0, 0, 0, 0, 48'h0, 8'h20, 1'b0);
    send_ray(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 48'd5, 8'h40, 1'b1);
  endtask

  task automatic test_extremes();
    for (int i = 0; i < 6; i++)
      send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
               32'h7FFF_FFFF, 32'h8000_0000, i[0] ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000,
               i[1] ? 8'hFF : 8'h00, i == 5);
  endtask

  task automatic test_random_clouds(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_random_ray(i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_x = '0; in_start_y = '0; in_start_z = '0;
    in_end_x = '0; in_end_y = '0; in_end_z = '0;
    in_time_stamp = '0;
    in_alpha = '0;
    in_last_ray = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_summary();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28; recv_idle_pct = 46;
    test_single_rays();
    test_time_ties();
    test_centroid_rounding();
    test_extremes();
    test_random_clouds(80);
    send_idle_pct = 46; recv_idle_pct = 28;
    test_random_clouds(80);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_clouds(80);

    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d rays in %0d clouds, %0d summary words checked",
             n_rays, n_clouds, n_words);
    $display("idle mixes: sender 28/receiver 46, 46/28, none");
    if (n_fail == 0 && pending_summary.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
